### rtl/core/tts_pkg.sv
// ----------------------------------------------------------------------------
// tts_pkg: shared constants for the task timer scheduler
// Field widths, table geometry, opcodes and event kinds.
// ----------------------------------------------------------------------------
package tts_pkg;

  // Table geometry and tick length
  localparam int SLOTS       = 8;
  localparam int TICK_MS     = 10;
  localparam int MAX_RESULTS = 8;

  // Field widths
  localparam int OPCODE_W  = 2;
  localparam int MS_W      = 32;
  localparam int SLOT_ID_W = 3;
  localparam int KIND_W    = 3;
  localparam int SLOT_NO_W = 3;
  localparam int TICK_W    = 29;

  // Derived widths
  localparam int IDX_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int FIRE_CNT_W = $clog2(MAX_RESULTS + 1);

  // Scaled reciprocal of the tick length; the floor quotient is exact for
  // every dividend of MS_W bits
  localparam int RECIP_SHIFT = MS_W + $clog2(TICK_MS);
  localparam logic [MS_W:0] RECIP =
    (MS_W+1)'(((64'd1 << RECIP_SHIFT) + 64'(TICK_MS - 1)) / 64'(TICK_MS));

  localparam logic [TICK_W-1:0] TICK_LIMIT = '1;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd2;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_FIRED   = 3'd0;
  localparam logic [KIND_W-1:0] EV_ADDED   = 3'd1;
  localparam logic [KIND_W-1:0] EV_FULL    = 3'd2;
  localparam logic [KIND_W-1:0] EV_DELETED = 3'd3;
  localparam logic [KIND_W-1:0] EV_EMPTY   = 3'd4;

endpackage

### rtl/core/tts_if.sv
// ----------------------------------------------------------------------------
// tts_if: request and result channels of the task timer scheduler
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic                           valid;
  logic                           ready;
  logic [tts_pkg::OPCODE_W-1:0]   opcode;
  logic [tts_pkg::MS_W-1:0]       delay_ms;
  logic [tts_pkg::MS_W-1:0]       period_ms;
  logic [tts_pkg::SLOT_ID_W-1:0]  slot_id;

  modport source (output valid, opcode, delay_ms, period_ms, slot_id, input ready);
  modport sink   (input valid, opcode, delay_ms, period_ms, slot_id, output ready);
endinterface

interface tts_out_if;
  logic                           valid;
  logic                           ready;
  logic [tts_pkg::KIND_W-1:0]     event_kind;
  logic [tts_pkg::SLOT_NO_W-1:0]  slot_number;
  logic                           last_of_run;

  modport source (output valid, event_kind, slot_number, last_of_run, input ready);
  modport sink   (input valid, event_kind, slot_number, last_of_run, output ready);
endinterface

### rtl/core/tts_div.sv
// ----------------------------------------------------------------------------
// tts_div: divider by the tick length
// Multiplies by a scaled reciprocal; the quotient is registered and ready in
// the cycle after start.
// ----------------------------------------------------------------------------
module tts_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tts_pkg::MS_W-1:0]  dividend,
  output logic                      done,
  output logic [tts_pkg::MS_W-1:0]  quotient
);

  logic                              done_r;
  logic [tts_pkg::MS_W-1:0]          quo_r;
  logic [2*tts_pkg::MS_W:0]          prod;

  // Multiply by the reciprocal of the tick length
  assign prod = {{(tts_pkg::MS_W+1){1'b0}}, dividend} *
                {{tts_pkg::MS_W{1'b0}}, tts_pkg::RECIP};

  // Control: done follows start in the next cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= start;
    end
  end

  // Datapath: keep the integer part of the scaled product
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= tts_pkg::MS_W'(prod >> tts_pkg::RECIP_SHIFT);
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### rtl/core/task_timer_scheduler_core.sv
// ----------------------------------------------------------------------------
// task_timer_scheduler_core: table of timed task slots
// Add, delete and tick requests against a fixed slot table; fired tasks are
// reported in slot order.
// ----------------------------------------------------------------------------
// A delete, or an add that finds the table full, goes from the accept state
// through S_EMIT back to idle. An add goes through S_DIV_DLY and S_DIV_PER:
// delay and period go one after the other through a single reciprocal-multiply
// divider (start, then capture), and S_EMIT hands the report on. A tick goes
// from the accept state to S_SCAN, where one shared decrement-and-compare unit
// visits one slot per cycle unless the scan stalls, then S_FLUSH drains the
// last report. Ready is low while a request is in progress; a result held
// in the output register does not block the next request, but a request
// stalls while its report cannot be handed on, and a tick stalls its scan
// while its second pending report cannot be handed on.
// ----------------------------------------------------------------------------
module task_timer_scheduler_core (
  input  logic      clk,
  input  logic      rst_n,
  tts_in_if.sink    in_ch,
  tts_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_DLY,
    S_DIV_PER,
    S_SCAN,
    S_FLUSH,
    S_EMIT
  } state_t;

  state_t                              state_r;

  // Slot table
  logic                                used_r   [tts_pkg::SLOTS];
  logic [tts_pkg::TICK_W-1:0]          remain_r [tts_pkg::SLOTS];
  logic [tts_pkg::TICK_W-1:0]          period_r [tts_pkg::SLOTS];

  // Request holding
  logic [tts_pkg::MS_W-1:0]            dly_ms_r;
  logic [tts_pkg::MS_W-1:0]            per_ms_r;
  logic [tts_pkg::TICK_W-1:0]          dly_ticks_r;
  logic [tts_pkg::IDX_W-1:0]           add_idx_r;
  logic [tts_pkg::KIND_W-1:0]          res_kind_r;
  logic [tts_pkg::SLOT_NO_W-1:0]       res_slot_r;

  // Tick scan
  logic [tts_pkg::IDX_W-1:0]           scan_idx_r;
  logic [tts_pkg::FIRE_CNT_W-1:0]      fire_cnt_r;
  logic                                pend_valid_r;
  logic [tts_pkg::SLOT_NO_W-1:0]       pend_slot_r;

  // Output register
  logic                                out_valid_r;
  logic [tts_pkg::KIND_W-1:0]          out_kind_r;
  logic [tts_pkg::SLOT_NO_W-1:0]       out_slot_r;
  logic                                out_last_r;

  // Divider link
  logic                                div_start_r;
  logic [tts_pkg::MS_W-1:0]            div_dividend;
  logic                                div_done;
  logic [tts_pkg::MS_W-1:0]            div_q;
  logic [tts_pkg::TICK_W-1:0]          div_ticks;

  logic                                in_accept;
  logic                                out_free;
  logic                                free_found;
  logic [tts_pkg::IDX_W-1:0]           free_idx;
  logic [tts_pkg::IDX_W+tts_pkg::SLOT_ID_W-1:0] del_ext;
  logic                                del_valid;
  logic [tts_pkg::IDX_W-1:0]           del_idx;
  logic [tts_pkg::IDX_W+tts_pkg::SLOT_NO_W-1:0] scan_ext;
  logic [tts_pkg::IDX_W+tts_pkg::SLOT_NO_W-1:0] add_ext;
  logic [tts_pkg::SLOT_NO_W-1:0]       scan_slot;
  logic [tts_pkg::SLOT_NO_W-1:0]       add_slot;
  logic                                cur_used;
  logic [tts_pkg::TICK_W-1:0]          cur_rem;
  logic [tts_pkg::TICK_W-1:0]          cur_per;
  logic [tts_pkg::TICK_W-1:0]          cur_dec;
  logic                                cur_fire;
  logic                                cur_report;
  logic                                scan_stall;

  // Handshake
  assign in_accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_kind_r;
  assign out_ch.slot_number = out_slot_r;
  assign out_ch.last_of_run = out_last_r;

  // Divide delay first, then period
  assign div_dividend = (state_r == S_DIV_DLY) ? dly_ms_r : per_ms_r;

  tts_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start_r),
    .dividend (div_dividend),
    .done     (div_done),
    .quotient (div_q)
  );

  // Saturate the tick count to the counter range
  assign div_ticks = (div_q > {{(tts_pkg::MS_W-tts_pkg::TICK_W){1'b0}}, tts_pkg::TICK_LIMIT})
                     ? tts_pkg::TICK_LIMIT : div_q[tts_pkg::TICK_W-1:0];

  // Find the lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = tts_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        free_found = 1'b1;
        free_idx   = tts_pkg::IDX_W'(i);
      end
    end
  end

  // Delete target range check
  assign del_ext   = {{tts_pkg::IDX_W{1'b0}}, in_ch.slot_id};
  assign del_valid = (del_ext < (tts_pkg::IDX_W+tts_pkg::SLOT_ID_W)'(tts_pkg::SLOTS));
  assign del_idx   = del_ext[tts_pkg::IDX_W-1:0];

  // Slot numbers carry the low index bits
  assign scan_ext  = {{tts_pkg::SLOT_NO_W{1'b0}}, scan_idx_r};
  assign add_ext   = {{tts_pkg::SLOT_NO_W{1'b0}}, add_idx_r};
  assign scan_slot = scan_ext[tts_pkg::SLOT_NO_W-1:0];
  assign add_slot  = add_ext[tts_pkg::SLOT_NO_W-1:0];

  // Shared decrement and compare for the slot under scan
  always_comb begin
    cur_used   = used_r[scan_idx_r];
    cur_rem    = remain_r[scan_idx_r];
    cur_per    = period_r[scan_idx_r];
    cur_dec    = cur_rem - tts_pkg::TICK_W'(cur_rem != '0);
    cur_fire   = cur_used && (cur_dec == '0);
    cur_report = cur_fire && (fire_cnt_r < tts_pkg::FIRE_CNT_W'(tts_pkg::MAX_RESULTS));
    scan_stall = cur_report && pend_valid_r && !out_free;
  end

  // Sequencer, occupancy marks and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      div_start_r  <= 1'b0;
      for (int i = 0; i < tts_pkg::SLOTS; i++) begin
        used_r[i] <= 1'b0;
      end
    end else begin
      div_start_r <= 1'b0;
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            case (in_ch.opcode)
              tts_pkg::OP_TICK: begin
                scan_idx_r   <= '0;
                fire_cnt_r   <= '0;
                pend_valid_r <= 1'b0;
                state_r      <= S_SCAN;
              end
              tts_pkg::OP_ADD: begin
                dly_ms_r <= in_ch.delay_ms;
                per_ms_r <= in_ch.period_ms;
                if (free_found) begin
                  add_idx_r   <= free_idx;
                  div_start_r <= 1'b1;
                  state_r     <= S_DIV_DLY;
                end else begin
                  res_kind_r <= tts_pkg::EV_FULL;
                  res_slot_r <= '0;
                  state_r    <= S_EMIT;
                end
              end
              tts_pkg::OP_DELETE: begin
                res_slot_r <= in_ch.slot_id;
                if (del_valid && used_r[del_idx]) begin
                  used_r[del_idx] <= 1'b0;
                  res_kind_r      <= tts_pkg::EV_DELETED;
                end else begin
                  res_kind_r <= tts_pkg::EV_EMPTY;
                end
                state_r <= S_EMIT;
              end
              default: begin
                state_r <= S_IDLE;
              end
            endcase
          end
        end
        S_DIV_DLY: begin
          if (div_done) begin
            dly_ticks_r <= div_ticks;
            div_start_r <= 1'b1;
            state_r     <= S_DIV_PER;
          end
        end
        S_DIV_PER: begin
          if (div_done) begin
            used_r[add_idx_r] <= 1'b1;
            res_kind_r        <= tts_pkg::EV_ADDED;
            res_slot_r        <= add_slot;
            state_r           <= S_EMIT;
          end
        end
        S_SCAN: begin
          if (!scan_stall) begin
            // Free a fired one-shot task
            if (cur_fire && cur_per == '0) begin
              used_r[scan_idx_r] <= 1'b0;
            end
            // Hand the older report on, hold the new one
            if (cur_report) begin
              fire_cnt_r   <= fire_cnt_r + 1'b1;
              pend_valid_r <= 1'b1;
              pend_slot_r  <= scan_slot;
              if (pend_valid_r) begin
                out_valid_r <= 1'b1;
                out_kind_r  <= tts_pkg::EV_FIRED;
                out_slot_r  <= pend_slot_r;
                out_last_r  <= 1'b0;
              end
            end
            if (scan_idx_r == tts_pkg::IDX_W'(tts_pkg::SLOTS - 1)) begin
              state_r <= S_FLUSH;
            end else begin
              scan_idx_r <= scan_idx_r + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            out_valid_r  <= 1'b1;
            out_kind_r   <= tts_pkg::EV_FIRED;
            out_slot_r   <= pend_slot_r;
            out_last_r   <= 1'b1;
            pend_valid_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_kind_r  <= res_kind_r;
            out_slot_r  <= res_slot_r;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Slot counts: load on add, count down or reload on tick
  always_ff @(posedge clk) begin
    if (state_r == S_DIV_PER && div_done) begin
      remain_r[add_idx_r] <= dly_ticks_r;
      period_r[add_idx_r] <= div_ticks;
    end else if (state_r == S_SCAN && !scan_stall && cur_used) begin
      remain_r[scan_idx_r] <= cur_fire ? cur_per : cur_dec;
    end
  end

endmodule

### dv/tb_task_timer_scheduler_core.sv
// ----------------------------------------------------------------------------
// tb_task_timer_scheduler_core: self-checking bench for the task timer table
// Drives add, delete, tick and ignored-opcode requests with random gaps, and
// predicts every report from a slot table kept in the bench. Each report is
// checked field by field, in order, against what the slot table predicts.
// ----------------------------------------------------------------------------
module tb_task_timer_scheduler_core;

  // Opcode the block must ignore
  localparam logic [tts_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_REQS = 375;
  localparam int DRAIN_CYCLES = 120;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic [tts_pkg::OPCODE_W-1:0]  opcode;
    logic [tts_pkg::MS_W-1:0]      delay_ms;
    logic [tts_pkg::MS_W-1:0]      period_ms;
    logic [tts_pkg::SLOT_ID_W-1:0] slot_id;
  } sched_req_t;

  typedef struct packed {
    logic [tts_pkg::KIND_W-1:0]    kind;
    logic [tts_pkg::SLOT_NO_W-1:0] slot;
    logic                          last;
  } sched_event_t;

  logic clk;
  logic rst_n;

  tts_in_if  in_ch();
  tts_out_if out_ch();

  task_timer_scheduler_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Requests waiting to be driven, and reports the slot table still owes
  sched_req_t   req_backlog[$];
  sched_event_t pending_events[$];

  // Slot table as the bench sees it
  logic                       slot_busy[tts_pkg::SLOTS];
  logic [tts_pkg::TICK_W-1:0] ticks_left[tts_pkg::SLOTS];
  logic [tts_pkg::TICK_W-1:0] reload_ticks[tts_pkg::SLOTS];

  sched_req_t on_bus;
  logic       in_take;
  logic       out_take;
  int         in_gap;
  int         out_stall;
  int         in_calm;
  int         out_calm;

  int mismatches;
  int events_seen;
  int n_ticks;
  int n_adds;
  int n_deletes;
  int n_ignored;
  int n_fired;
  int n_full;
  int n_empty_del;

  // Clock: 20 time units per period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Wait draw with occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [tts_pkg::TICK_W-1:0] ms_to_ticks(logic [tts_pkg::MS_W-1:0] ms);
    logic [tts_pkg::MS_W-1:0] q;
    q = ms / tts_pkg::TICK_MS;
    if (q > tts_pkg::MS_W'(tts_pkg::TICK_LIMIT)) begin
      return tts_pkg::TICK_LIMIT;
    end
    return q[tts_pkg::TICK_W-1:0];
  endfunction

  // Advance the slot table by one request and queue the reports it causes
  function automatic void step_slot_table(sched_req_t r);
    sched_event_t run[$];
    sched_event_t ev;
    int           free_slot;
    int           id;
    free_slot = -1;
    case (r.opcode)
      tts_pkg::OP_TICK: begin
        n_ticks++;
        for (int i = 0; i < tts_pkg::SLOTS; i++) begin
          if (slot_busy[i]) begin
            if (ticks_left[i] != 0) begin
              ticks_left[i] = ticks_left[i] - 1'b1;
            end
            if (ticks_left[i] == 0) begin
              if (run.size() < tts_pkg::MAX_RESULTS) begin
                ev.kind = tts_pkg::EV_FIRED;
                ev.slot = tts_pkg::SLOT_NO_W'(i);
                ev.last = 1'b0;
                run.push_back(ev);
              end
              // Free one-shot tasks, reload periodic ones
              if (reload_ticks[i] == 0) begin
                slot_busy[i] = 1'b0;
              end else begin
                ticks_left[i] = reload_ticks[i];
              end
            end
          end
        end
      end
      tts_pkg::OP_ADD: begin
        n_adds++;
        for (int i = 0; i < tts_pkg::SLOTS; i++) begin
          if (!slot_busy[i] && free_slot < 0) begin
            free_slot = i;
          end
        end
        if (free_slot < 0) begin
          ev.kind = tts_pkg::EV_FULL;
          ev.slot = '0;
        end else begin
          slot_busy[free_slot]    = 1'b1;
          ticks_left[free_slot]   = ms_to_ticks(r.delay_ms);
          reload_ticks[free_slot] = ms_to_ticks(r.period_ms);
          ev.kind = tts_pkg::EV_ADDED;
          ev.slot = tts_pkg::SLOT_NO_W'(free_slot);
        end
        ev.last = 1'b0;
        run.push_back(ev);
      end
      tts_pkg::OP_DELETE: begin
        n_deletes++;
        id = int'(r.slot_id);
        if (id < tts_pkg::SLOTS && slot_busy[id]) begin
          slot_busy[id]    = 1'b0;
          ticks_left[id]   = '0;
          reload_ticks[id] = '0;
          ev.kind = tts_pkg::EV_DELETED;
        end else begin
          ev.kind = tts_pkg::EV_EMPTY;
        end
        ev.slot = tts_pkg::SLOT_NO_W'(r.slot_id);
        ev.last = 1'b0;
        run.push_back(ev);
      end
      default: begin
        n_ignored++;
      end
    endcase
    if (run.size() > 0) begin
      run[run.size()-1].last = 1'b1;
    end
    foreach (run[k]) begin
      pending_events.push_back(run[k]);
    end
  endfunction

  task automatic queue_req(logic [tts_pkg::OPCODE_W-1:0] op, logic [tts_pkg::MS_W-1:0] d_ms,
                           logic [tts_pkg::MS_W-1:0] p_ms,
                           logic [tts_pkg::SLOT_ID_W-1:0] id);
    sched_req_t r;
    r.opcode    = op;
    r.delay_ms  = d_ms;
    r.period_ms = p_ms;
    r.slot_id   = id;
    req_backlog.push_back(r);
  endtask

  function automatic logic [tts_pkg::MS_W-1:0] draw_delay();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return tts_pkg::MS_W'($urandom_range(0, 60));
    if (pick < 90) return tts_pkg::MS_W'($urandom_range(0, 1000));
    return $urandom();
  endfunction

  function automatic logic [tts_pkg::MS_W-1:0] draw_period();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return tts_pkg::MS_W'($urandom_range(0, tts_pkg::TICK_MS - 1));
    if (pick < 70) return tts_pkg::MS_W'($urandom_range(0, 60));
    if (pick < 90) return tts_pkg::MS_W'($urandom_range(10, 200));
    return $urandom();
  endfunction

  // Driver: hold the request until it moves, then wait the drawn gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid     <= 1'b0;
      in_ch.opcode    <= tts_pkg::OP_TICK;
      in_ch.delay_ms  <= '0;
      in_ch.period_ms <= '0;
      in_ch.slot_id   <= '0;
    end else begin
      in_take = in_ch.valid && in_ch.ready;
      if (in_take) begin
        step_slot_table(on_bus);
        in_gap = draw_wait(in_calm);
      end
      if (!in_ch.valid || in_take) begin
        if (in_gap == 0 && req_backlog.size() > 0) begin
          on_bus = req_backlog.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.opcode    <= on_bus.opcode;
          in_ch.delay_ms  <= on_bus.delay_ms;
          in_ch.period_ms <= on_bus.period_ms;
          in_ch.slot_id   <= on_bus.slot_id;
        end else begin
          in_ch.valid <= 1'b0;
          if (in_gap > 0) begin
            in_gap--;
          end
        end
      end
    end
  end

  // Monitor: check each report against the oldest expectation, then stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_take = out_ch.valid && out_ch.ready;
      if (out_take) begin
        events_seen++;
        if (out_ch.event_kind == tts_pkg::EV_FIRED) n_fired++;
        if (out_ch.event_kind == tts_pkg::EV_FULL) n_full++;
        if (out_ch.event_kind == tts_pkg::EV_EMPTY) n_empty_del++;
        if (pending_events.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("unexpected report: kind %0d slot %0d last %0d",
                     out_ch.event_kind, out_ch.slot_number, out_ch.last_of_run);
          end
        end else begin
          sched_event_t want;
          want = pending_events.pop_front();
          if (out_ch.event_kind !== want.kind || out_ch.slot_number !== want.slot ||
              out_ch.last_of_run !== want.last) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("report %0d mismatch: expected kind %0d slot %0d last %0d,",
                       events_seen, want.kind, want.slot, want.last);
              $display("  got kind %0d slot %0d last %0d",
                       out_ch.event_kind, out_ch.slot_number, out_ch.last_of_run);
            end
          end
        end
        out_stall = draw_wait(out_calm);
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  initial begin
    #12_000_000;
    $display("timeout with %0d requests unsent, %0d reports owed",
             req_backlog.size(), pending_events.size());
    $display("tb_task_timer_scheduler_core NOT OK");
    $finish;
  end

  // Stimulus, reset and end of run
  initial begin
    int counted;
    int pick;
    in_ch.valid     = 1'b0;
    in_ch.opcode    = tts_pkg::OP_TICK;
    in_ch.delay_ms  = '0;
    in_ch.period_ms = '0;
    in_ch.slot_id   = '0;
    out_ch.ready    = 1'b0;
    rst_n           = 1'b0;
    in_gap = 0; out_stall = 0; in_calm = 0; out_calm = 0;
    mismatches = 0; events_seen = 0;
    n_ticks = 0; n_adds = 0; n_deletes = 0; n_ignored = 0;
    n_fired = 0; n_full = 0; n_empty_del = 0;
    for (int i = 0; i < tts_pkg::SLOTS; i++) begin
      slot_busy[i]    = 1'b0;
      ticks_left[i]   = '0;
      reload_ticks[i] = '0;
    end

    // Directed: empty tick, ignored opcode, delete of an empty slot
    queue_req(tts_pkg::OP_TICK, 32'd0, 32'd0, 3'd0);
    queue_req(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7);
    queue_req(tts_pkg::OP_DELETE, 32'd0, 32'd0, 3'd0);
    // Fill the table with tasks that all come due on the first tick
    queue_req(tts_pkg::OP_ADD, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd9, 32'd9, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd10, 32'd10, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd19, 32'hFFFF_FFFF, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd5, 32'd20, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd1, 32'd30, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd10, 32'd10, 3'd0);
    queue_req(tts_pkg::OP_ADD, 32'd10, 32'd10, 3'd0);
    // Eight firings on one tick, then periodic reloads
    queue_req(tts_pkg::OP_TICK, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_TICK, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_DELETE, 32'd0, 32'd0, 3'd2);
    queue_req(tts_pkg::OP_DELETE, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_DELETE, 32'd0, 32'd0, 3'd7);
    queue_req(tts_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd5);
    queue_req(tts_pkg::OP_TICK, 32'd0, 32'd0, 3'd0);
    queue_req(tts_pkg::OP_DELETE, 32'd0, 32'd0, 3'd3);

    // Random mix; ignored opcodes do not count toward the total
    counted = 0;
    while (counted < RANDOM_REQS) begin
      pick = $urandom_range(0, 99);
      if (pick < 42) begin
        queue_req(tts_pkg::OP_TICK, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
        counted++;
      end else if (pick < 74) begin
        queue_req(tts_pkg::OP_ADD, draw_delay(), draw_period(), 3'($urandom_range(0, 7)));
        counted++;
      end else if (pick < 94) begin
        queue_req(tts_pkg::OP_DELETE, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
        counted++;
      end else begin
        queue_req(OP_UNUSED, $urandom(), $urandom(), 3'($urandom_range(0, 7)));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: everything sent, every report back, then let the block settle
    wait (rst_n && req_backlog.size() == 0 && !in_ch.valid);
    wait (pending_events.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_events.size() != 0) begin
      mismatches += pending_events.size();
      $display("%0d expected reports never arrived", pending_events.size());
    end

    $display("ran %0d ticks, %0d adds, %0d deletes and %0d ignored requests",
             n_ticks, n_adds, n_deletes, n_ignored);
    $display("checked %0d reports: %0d firings, %0d full-table, %0d empty deletes,",
             events_seen, n_fired, n_full, n_empty_del);
    $display("  %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("tb_task_timer_scheduler_core OK");
    end else begin
      $display("tb_task_timer_scheduler_core NOT OK");
    end
    $finish;
  end

endmodule
